// ===== src/esc_pkg.sv =====
// Shared constants, widths and month tables for the epoch-to-calendar pipeline.
// No dependencies; imported by every module of the block.
package esc_pkg;

    localparam int NUM_STAGES = 9;

    localparam int EPOCH_W  = 32;
    localparam int ZONE_W   = 11;
    localparam int DAYS_W   = 16;
    localparam int DSEC_W   = 17;
    localparam int MTOT_W   = 11;
    localparam int YDAY_W   = 9;
    localparam int YEAR_W   = 12;
    localparam int MONTH_W  = 4;

    localparam logic signed [ZONE_W-1:0] ZONE_OFFSET_RESET = -11'sd420;

    // first instant past 2099-12-31 23:59:59
    localparam logic [33:0] END_SECONDS = 34'd4102444800;
    localparam logic [YEAR_W-1:0] BASE_YEAR = 12'd1970;

    // seconds of a day split as 675 * 128: the low 7 bits pass straight through
    localparam int DAY_LOW_BITS = 7;
    localparam int DAY_HI_DIV   = 675;

    // exact reciprocals: q = (x * RECIP) >> SHIFT for the whole input range
    localparam int DAY_SHIFT = 35;
    localparam logic [25:0] DAY_RECIP =
        26'(((64'd1 << DAY_SHIFT) + 64'(DAY_HI_DIV) - 64'd1) / 64'(DAY_HI_DIV));

    localparam int MIN_SHIFT = 23;
    localparam logic [17:0] MIN_RECIP = 18'(((64'd1 << MIN_SHIFT) + 64'd59) / 64'd60);

    localparam int HOUR_SHIFT = 17;
    localparam logic [11:0] HOUR_RECIP = 12'(((64'd1 << HOUR_SHIFT) + 64'd59) / 64'd60);

    localparam int QUAD_SHIFT = 27;
    localparam logic [16:0] QUAD_RECIP = 17'(((64'd1 << QUAD_SHIFT) + 64'd1459) / 64'd1460);

    localparam int YEAR_SHIFT = 25;
    localparam logic [16:0] YEAR_RECIP = 17'(((64'd1 << YEAR_SHIFT) + 64'd364) / 64'd365);

    localparam int WEEK_SHIFT = 19;
    localparam logic [16:0] WEEK_RECIP = 17'(((64'd1 << WEEK_SHIFT) + 64'd6) / 64'd7);

    localparam logic [YDAY_W-1:0] MONTH_START_COMMON [13] = '{
        9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151, 9'd181,
        9'd212, 9'd243, 9'd273, 9'd304, 9'd334, 9'd365
    };
    localparam logic [YDAY_W-1:0] MONTH_START_LEAP [13] = '{
        9'd0, 9'd31, 9'd60, 9'd91, 9'd121, 9'd152, 9'd182,
        9'd213, 9'd244, 9'd274, 9'd305, 9'd335, 9'd366
    };

    function automatic logic [YDAY_W-1:0] month_start(input logic leap,
                                                      input logic [MONTH_W-1:0] idx);
        logic [YDAY_W-1:0] val;
        if (leap)
        begin
            val = MONTH_START_LEAP[idx];
        end
        else
        begin
            val = MONTH_START_COMMON[idx];
        end
        return val;
    endfunction

endpackage

// ===== src/esc_pipe_ctrl.sv =====
// Valid bits and per-stage load enables for the conversion pipeline.
// Depends on esc_pkg for the stage count.
module esc_pipe_ctrl
    import esc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [NUM_STAGES-1:0] en
);

    logic [NUM_STAGES-1:0] valid_reg;
    logic [NUM_STAGES-1:0] valid_next;
    logic [NUM_STAGES:0]   stage_ready;

    // a stage takes new data when it is empty or its content moves on
    always_comb
    begin
        stage_ready[NUM_STAGES] = out_ready;
        for (int i = NUM_STAGES - 1; i >= 0; i--)
        begin
            stage_ready[i] = !valid_reg[i] || stage_ready[i+1];
        end
    end

    always_comb
    begin
        en = stage_ready[NUM_STAGES-1:0];
        valid_next[0] = stage_ready[0] ? in_valid : valid_reg[0];
        for (int i = 1; i < NUM_STAGES; i++)
        begin
            valid_next[i] = stage_ready[i] ? valid_reg[i-1] : valid_reg[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    assign in_ready  = stage_ready[0];
    assign out_valid = valid_reg[NUM_STAGES-1];

endmodule

// ===== src/esc_day_split.sv =====
// Stages 1 to 3: zone offset, range check, split into day count and second of day.
// Depends on esc_pkg for widths, limits and the day reciprocal.
module esc_day_split
    import esc_pkg::*;
(
    input  logic                     clk,
    input  logic [2:0]               en,
    input  logic [EPOCH_W-1:0]       epoch_seconds,
    input  logic signed [ZONE_W-1:0] zone_offset,
    output logic [DAYS_W-1:0]        days,
    output logic [DSEC_W-1:0]        sec_of_day,
    output logic                     oor
);

    localparam int HI_W = EPOCH_W - DAY_LOW_BITS;

    // stage 1
    logic signed [17:0] off_ext;
    logic signed [17:0] off_sec;
    logic [34:0]        t_next;
    logic               oor1_next;
    logic [EPOCH_W-1:0] t1_reg;
    logic               oor1_reg;

    assign off_ext   = 18'(zone_offset);
    assign off_sec   = off_ext * 18'sd60;
    assign t_next    = {3'b000, epoch_seconds} + 35'(off_sec);
    assign oor1_next = t_next[34] || (t_next[33:0] >= END_SECONDS);

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            t1_reg   <= t_next[EPOCH_W-1:0];
            oor1_reg <= oor1_next;
        end
    end

    // stage 2: day number by reciprocal of 675 on the upper bits
    logic [HI_W+25:0]        prod2_next;
    logic [DAYS_W-1:0]       q2_reg;
    logic [HI_W-1:0]         x2_reg;
    logic [DAY_LOW_BITS-1:0] low2_reg;
    logic                    oor2_reg;

    assign prod2_next = (HI_W+26)'(t1_reg[EPOCH_W-1:DAY_LOW_BITS]) * (HI_W+26)'(DAY_RECIP);

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            q2_reg   <= prod2_next[DAY_SHIFT+DAYS_W-1:DAY_SHIFT];
            x2_reg   <= t1_reg[EPOCH_W-1:DAY_LOW_BITS];
            low2_reg <= t1_reg[DAY_LOW_BITS-1:0];
            oor2_reg <= oor1_reg;
        end
    end

    // stage 3: remainder rebuilt into second of day
    logic [HI_W-1:0] rem3_next;
    logic [DAYS_W-1:0] days_reg;
    logic [DSEC_W-1:0] sec_of_day_reg;
    logic              oor3_reg;

    assign rem3_next = x2_reg - HI_W'(HI_W'(q2_reg) * HI_W'(DAY_HI_DIV));

    always_ff @(posedge clk)
    begin
        if (en[2])
        begin
            days_reg       <= q2_reg;
            sec_of_day_reg <= {rem3_next[DSEC_W-DAY_LOW_BITS-1:0], low2_reg};
            oor3_reg       <= oor2_reg;
        end
    end

    assign days       = days_reg;
    assign sec_of_day = sec_of_day_reg;
    assign oor        = oor3_reg;

endmodule

// ===== src/esc_clock_split.sv =====
// Stages 4 to 8: second of day into hour, minute and second.
// Depends on esc_pkg for widths and reciprocals of 60.
module esc_clock_split
    import esc_pkg::*;
(
    input  logic              clk,
    input  logic [4:0]        en,
    input  logic [DSEC_W-1:0] sec_of_day,
    output logic [5:0]        second,
    output logic [5:0]        minute,
    output logic [4:0]        hour
);

    // stage 4: minute of day
    logic [DSEC_W+17:0] prod4_next;
    logic [MTOT_W-1:0]  mt4_reg;
    logic [DSEC_W-1:0]  ds4_reg;

    assign prod4_next = (DSEC_W+18)'(sec_of_day) * (DSEC_W+18)'(MIN_RECIP);

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            mt4_reg <= prod4_next[MIN_SHIFT+MTOT_W-1:MIN_SHIFT];
            ds4_reg <= sec_of_day;
        end
    end

    // stage 5: second
    logic [DSEC_W-1:0] sec5_next;
    logic [MTOT_W-1:0] mt5_reg;
    logic [5:0]        sec5_reg;

    assign sec5_next = ds4_reg - DSEC_W'(DSEC_W'(mt4_reg) * DSEC_W'(60));

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            mt5_reg  <= mt4_reg;
            sec5_reg <= sec5_next[5:0];
        end
    end

    // stage 6: hour
    logic [MTOT_W+11:0] prod6_next;
    logic [4:0]         hour6_reg;
    logic [MTOT_W-1:0]  mt6_reg;
    logic [5:0]         sec6_reg;

    assign prod6_next = (MTOT_W+12)'(mt5_reg) * (MTOT_W+12)'(HOUR_RECIP);

    always_ff @(posedge clk)
    begin
        if (en[2])
        begin
            hour6_reg <= prod6_next[HOUR_SHIFT+4:HOUR_SHIFT];
            mt6_reg   <= mt5_reg;
            sec6_reg  <= sec5_reg;
        end
    end

    // stage 7: minute
    logic [MTOT_W-1:0] min7_next;
    logic [4:0]        hour7_reg;
    logic [5:0]        min7_reg;
    logic [5:0]        sec7_reg;

    assign min7_next = mt6_reg - MTOT_W'(MTOT_W'(hour6_reg) * MTOT_W'(60));

    always_ff @(posedge clk)
    begin
        if (en[3])
        begin
            hour7_reg <= hour6_reg;
            min7_reg  <= min7_next[5:0];
            sec7_reg  <= sec6_reg;
        end
    end

    // stage 8: aligned with the month search
    logic [4:0] hour8_reg;
    logic [5:0] min8_reg;
    logic [5:0] sec8_reg;

    always_ff @(posedge clk)
    begin
        if (en[4])
        begin
            hour8_reg <= hour7_reg;
            min8_reg  <= min7_reg;
            sec8_reg  <= sec7_reg;
        end
    end

    assign second = sec8_reg;
    assign minute = min8_reg;
    assign hour   = hour8_reg;

endmodule

// ===== src/esc_date_split.sv =====
// Stages 4 to 8: day count into year, month, day of month and day of week.
// Depends on esc_pkg for reciprocals and the month start tables.
module esc_date_split
    import esc_pkg::*;
(
    input  logic               clk,
    input  logic [4:0]         en,
    input  logic [DAYS_W-1:0]  days,
    output logic [YEAR_W-1:0]  year,
    output logic [MONTH_W-1:0] month,
    output logic [4:0]         day_of_month,
    output logic [2:0]         day_of_week
);

    // stage 4: quad-year correction and week quotient
    logic [DAYS_W-1:0]  qsum4;
    logic [DAYS_W-1:0]  wsum4;
    logic [DAYS_W+16:0] qprod4_next;
    logic [DAYS_W+16:0] wprod4_next;
    logic [DAYS_W-1:0]  days4_reg;
    logic [5:0]         a4_reg;
    logic [12:0]        wq4_reg;

    assign qsum4       = days + DAYS_W'(365);
    assign wsum4       = days + DAYS_W'(4);
    assign qprod4_next = (DAYS_W+17)'(qsum4) * (DAYS_W+17)'(QUAD_RECIP);
    assign wprod4_next = (DAYS_W+17)'(wsum4) * (DAYS_W+17)'(WEEK_RECIP);

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            days4_reg <= days;
            a4_reg    <= qprod4_next[QUAD_SHIFT+5:QUAD_SHIFT];
            wq4_reg   <= wprod4_next[WEEK_SHIFT+12:WEEK_SHIFT];
        end
    end

    // stage 5
    logic [DAYS_W-1:0] wrem5_next;
    logic [DAYS_W-1:0] days5_reg;
    logic [DAYS_W-1:0] b5_reg;
    logic [2:0]        wday5_reg;

    assign wrem5_next = DAYS_W'(days4_reg + DAYS_W'(4))
                      - DAYS_W'(DAYS_W'(wq4_reg) * DAYS_W'(7));

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            days5_reg <= days4_reg;
            b5_reg    <= days4_reg - DAYS_W'(a4_reg);
            wday5_reg <= wrem5_next[2:0];
        end
    end

    // stage 6: years since base
    logic [DAYS_W+16:0] yprod6_next;
    logic [DAYS_W-1:0]  days6_reg;
    logic [7:0]         years6_reg;
    logic [2:0]         wday6_reg;

    assign yprod6_next = (DAYS_W+17)'(b5_reg) * (DAYS_W+17)'(YEAR_RECIP);

    always_ff @(posedge clk)
    begin
        if (en[2])
        begin
            days6_reg  <= days5_reg;
            years6_reg <= yprod6_next[YEAR_SHIFT+7:YEAR_SHIFT];
            wday6_reg  <= wday5_reg;
        end
    end

    // stage 7: day of year, year, leap flag
    logic [DAYS_W-1:0] ystart7;
    logic [DAYS_W-1:0] ydiff7;
    logic [8:0]        ynext7;
    logic [YDAY_W-1:0] yday7_reg;
    logic [YEAR_W-1:0] year7_reg;
    logic              leap7_reg;
    logic [2:0]        wday7_reg;

    assign ynext7  = 9'(years6_reg) + 9'd1;
    assign ystart7 = DAYS_W'(DAYS_W'(years6_reg) * DAYS_W'(365)) + DAYS_W'(ynext7 >> 2);
    assign ydiff7  = days6_reg - ystart7;

    always_ff @(posedge clk)
    begin
        if (en[3])
        begin
            yday7_reg <= ydiff7[YDAY_W-1:0];
            year7_reg <= BASE_YEAR + YEAR_W'(years6_reg);
            // base year is two past a leap year
            leap7_reg <= (years6_reg[1:0] == 2'd2);
            wday7_reg <= wday6_reg;
        end
    end

    // stage 8: month from the start table, compares run in parallel
    logic [MONTH_W-1:0] month8_next;
    logic [MONTH_W-1:0] month8_reg;
    logic [YDAY_W-1:0]  yday8_reg;
    logic [YEAR_W-1:0]  year8_reg;
    logic               leap8_reg;
    logic [2:0]         wday8_reg;

    always_comb
    begin
        month8_next = MONTH_W'(1);
        for (int m = 1; m < 12; m++)
        begin
            if (yday7_reg >= month_start(leap7_reg, MONTH_W'(m)))
            begin
                month8_next = MONTH_W'(m + 1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[4])
        begin
            month8_reg <= month8_next;
            yday8_reg  <= yday7_reg;
            year8_reg  <= year7_reg;
            leap8_reg  <= leap7_reg;
            wday8_reg  <= wday7_reg;
        end
    end

    logic [YDAY_W-1:0] mday_full;

    assign mday_full = yday8_reg - month_start(leap8_reg, month8_reg - MONTH_W'(1))
                     + YDAY_W'(1);

    assign year         = year8_reg;
    assign month        = month8_reg;
    assign day_of_month = mday_full[4:0];
    assign day_of_week  = wday8_reg;

endmodule

// ===== src/epoch_seconds_to_calendar.sv =====
// Epoch seconds to local calendar date and time, fully pipelined.
// Usage:
//   input channel  : in_valid / in_ready carry epoch_seconds (unsigned seconds
//                    since 1970-01-01 00:00:00 UTC)
//   output channel : out_valid / out_ready carry second, minute, hour,
//                    day_of_month, month, year, day_of_week and out_of_range
//   config         : cfg_wen writes cfg_wdata (signed minutes from UTC) into
//                    the zone offset; write only while the pipeline is empty
// Each input passes through nine register stages before out_valid shows its
// result. Throughput is one item per cycle: every stage holds its own valid
// bit, so a new item enters each cycle while the output is taken.
// A local time before 1970 or from 2100 on gives out_of_range = 1 with all
// date and time fields zero.
// Reset empties the pipeline and loads the zone offset with -420 minutes.
// When out_ready is low the result holds at the output; earlier stages keep
// filling their empty slots, and in_ready drops once every stage is full.
// Depends on esc_pkg, esc_pipe_ctrl, esc_day_split, esc_clock_split, esc_date_split.
module epoch_seconds_to_calendar
    import esc_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_wen,
    input  logic signed [ZONE_W-1:0] cfg_wdata,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic [EPOCH_W-1:0]       epoch_seconds,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic [5:0]               second,
    output logic [5:0]               minute,
    output logic [4:0]               hour,
    output logic [4:0]               day_of_month,
    output logic [MONTH_W-1:0]       month,
    output logic [YEAR_W-1:0]        year,
    output logic [2:0]               day_of_week,
    output logic                     out_of_range
);

    logic signed [ZONE_W-1:0] zone_offset_minutes_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            zone_offset_minutes_reg <= ZONE_OFFSET_RESET;
        end
        else if (cfg_wen)
        begin
            zone_offset_minutes_reg <= cfg_wdata;
        end
    end

    logic [NUM_STAGES-1:0] en;

    esc_pipe_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .en        (en)
    );

    logic [DAYS_W-1:0] days;
    logic [DSEC_W-1:0] sec_of_day;
    logic              oor3;

    esc_day_split u_day (
        .clk           (clk),
        .en            (en[2:0]),
        .epoch_seconds (epoch_seconds),
        .zone_offset   (zone_offset_minutes_reg),
        .days          (days),
        .sec_of_day    (sec_of_day),
        .oor           (oor3)
    );

    logic [5:0] sec8;
    logic [5:0] min8;
    logic [4:0] hour8;

    esc_clock_split u_clock (
        .clk        (clk),
        .en         (en[7:3]),
        .sec_of_day (sec_of_day),
        .second     (sec8),
        .minute     (min8),
        .hour       (hour8)
    );

    logic [YEAR_W-1:0]  year8;
    logic [MONTH_W-1:0] month8;
    logic [4:0]         mday8;
    logic [2:0]         wday8;

    esc_date_split u_date (
        .clk          (clk),
        .en           (en[7:3]),
        .days         (days),
        .year         (year8),
        .month        (month8),
        .day_of_month (mday8),
        .day_of_week  (wday8)
    );

    // range flag rides along stages 4 to 8
    logic [4:0] oor_pipe_reg;

    always_ff @(posedge clk)
    begin
        if (en[3])
        begin
            oor_pipe_reg[0] <= oor3;
        end
        for (int i = 1; i < 5; i++)
        begin
            if (en[3+i])
            begin
                oor_pipe_reg[i] <= oor_pipe_reg[i-1];
            end
        end
    end

    // output stage, fields forced to zero when out of range
    logic               oor8;
    logic [5:0]         second_reg;
    logic [5:0]         minute_reg;
    logic [4:0]         hour_reg;
    logic [4:0]         day_of_month_reg;
    logic [MONTH_W-1:0] month_reg;
    logic [YEAR_W-1:0]  year_reg;
    logic [2:0]         day_of_week_reg;
    logic               out_of_range_reg;

    assign oor8 = oor_pipe_reg[4];

    always_ff @(posedge clk)
    begin
        if (en[NUM_STAGES-1])
        begin
            second_reg       <= oor8 ? '0 : sec8;
            minute_reg       <= oor8 ? '0 : min8;
            hour_reg         <= oor8 ? '0 : hour8;
            day_of_month_reg <= oor8 ? '0 : mday8;
            month_reg        <= oor8 ? '0 : month8;
            year_reg         <= oor8 ? '0 : year8;
            day_of_week_reg  <= oor8 ? '0 : wday8;
            out_of_range_reg <= oor8;
        end
    end

    assign second       = second_reg;
    assign minute       = minute_reg;
    assign hour         = hour_reg;
    assign day_of_month = day_of_month_reg;
    assign month        = month_reg;
    assign year         = year_reg;
    assign day_of_week  = day_of_week_reg;
    assign out_of_range = out_of_range_reg;

endmodule

// ===== src/esc_checker.sv =====
// Port-level checks for epoch_seconds_to_calendar, attached by bind.
// Depends on esc_pkg for field widths.
module esc_checker
    import esc_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               in_ready,
    input logic               out_valid,
    input logic               out_ready,
    input logic [5:0]         second,
    input logic [5:0]         minute,
    input logic [4:0]         hour,
    input logic [4:0]         day_of_month,
    input logic [MONTH_W-1:0] month,
    input logic [YEAR_W-1:0]  year,
    input logic [2:0]         day_of_week,
    input logic               out_of_range
);

    // a stalled result keeps year, month, day of month, second and range flag until its transfer
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(year) && $stable(month)
            && $stable(day_of_month) && $stable(second) && $stable(out_of_range))
        else $error("stalled result changed");

    // an empty output stage means the whole pipeline can take a transfer
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input blocked while output empty");

    a_oor_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_of_range |-> second == '0 && minute == '0 && hour == '0
            && day_of_month == '0 && month == '0 && year == '0 && day_of_week == '0)
        else $error("out of range result has nonzero fields");

    a_fields_legal: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_of_range |-> month >= 4'd1 && month <= 4'd12
            && day_of_month >= 5'd1 && hour <= 5'd23 && minute <= 6'd59
            && second <= 6'd59 && day_of_week <= 3'd6
            && year >= 12'd1970 && year <= 12'd2099)
        else $error("calendar field out of legal range");

endmodule

bind epoch_seconds_to_calendar esc_checker u_esc_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_ready     (in_ready),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .second       (second),
    .minute       (minute),
    .hour         (hour),
    .day_of_month (day_of_month),
    .month        (month),
    .year         (year),
    .day_of_week  (day_of_week),
    .out_of_range (out_of_range)
);
